>>> sv/assert_macros.svh
// Assertion macros shared by the RTL of the reflectance block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// A true antecedent requires the consequent in the same cycle.
`define FCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// A true antecedent requires the consequent in the next cycle.
`define FCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FCR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define FCR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/fcr_pkg.sv
package fcr_pkg;
    localparam int LANES_DEF = 4;
    localparam int COS_W     = 17;
    localparam int FIX_W     = 16;
    localparam int C_W       = 16;
    // Registered stages inside one lane, from input to reflectance.
    localparam int LANE_LAT  = 77;
    localparam logic [C_W-1:0]   ONE_Q15  = 16'h8000;
    localparam logic [FIX_W-1:0] REFL_MAX = 16'hFFFF;
    localparam logic [30:0]      ONE_Q30  = 31'h4000_0000;
endpackage

>>> sv/fcr_delay.sv
module fcr_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_pipe [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pipe[0] <= i_d;
            for (int i = 1; i < DEPTH; i++) begin
                r_pipe[i] <= r_pipe[i-1];
            end
        end
    end

    assign o_q = r_pipe[DEPTH-1];
endmodule

>>> sv/fcr_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module fcr_isqrt #(
    parameter int WIDTH = 64
) (
    input  logic               i_clk,
    input  logic               i_ce,
    input  logic [WIDTH-1:0]   i_x,
    output logic [WIDTH/2-1:0] o_root
);
    localparam int H = WIDTH / 2;

    logic [H+1:0]   r_rem  [H];
    logic [H-1:0]   r_root [H];
    logic [WIDTH-1:0] r_x  [H];

    for (genvar g = 0; g < H; g++) begin : g_stage
        logic [H+1:0]   in_rem;
        logic [H-1:0]   in_root;
        logic [WIDTH-1:0] in_x;
        logic [H+3:0]   t;
        logic [H+3:0]   trial;
        logic           ge;
        logic [H+3:0]   diff;

        if (g == 0) begin : g_first
            assign in_rem  = '0;
            assign in_root = '0;
            assign in_x    = i_x;
        end else begin : g_next
            assign in_rem  = r_rem[g-1];
            assign in_root = r_root[g-1];
            assign in_x    = r_x[g-1];
        end

        assign t     = {in_rem, in_x[WIDTH-1:WIDTH-2]};
        assign trial = {2'b00, in_root, 2'b01};
        assign ge    = (t >= trial);
        assign diff  = t - trial;

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g]  <= ge ? diff[H+1:0] : t[H+1:0];
                r_root[g] <= {in_root[H-2:0], ge};
                r_x[g]    <= {in_x[WIDTH-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[H-1];
endmodule

>>> sv/fcr_div.sv
// Pipelined Q16 ratio of num over den, one quotient bit per stage.
// A ratio at or above one gives exactly one (2^QBITS).
module fcr_div #(
    parameter int WIDTH = 54,
    parameter int QBITS = 16
) (
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic [QBITS:0]   o_q
);
    logic [WIDTH-1:0] r_rem [QBITS];
    logic [WIDTH-1:0] r_den [QBITS];
    logic [QBITS-1:0] r_q   [QBITS];
    logic             r_sat [QBITS];

    for (genvar g = 0; g < QBITS; g++) begin : g_stage
        logic [WIDTH-1:0] in_rem;
        logic [WIDTH-1:0] in_den;
        logic [QBITS-1:0] in_q;
        logic             in_sat;
        logic [WIDTH:0]   t;
        logic [WIDTH:0]   dsub;
        logic             ge;

        if (g == 0) begin : g_first
            assign in_rem = i_num;
            assign in_den = i_den;
            assign in_q   = '0;
            assign in_sat = (i_num >= i_den);
        end else begin : g_next
            assign in_rem = r_rem[g-1];
            assign in_den = r_den[g-1];
            assign in_q   = r_q[g-1];
            assign in_sat = r_sat[g-1];
        end

        assign t    = {in_rem, 1'b0};
        assign ge   = (t >= {1'b0, in_den});
        assign dsub = t - {1'b0, in_den};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[g] <= ge ? dsub[WIDTH-1:0] : t[WIDTH-1:0];
                r_den[g] <= in_den;
                r_q[g]   <= {in_q[QBITS-2:0], ge};
                r_sat[g] <= in_sat;
            end
        end
    end

    assign o_q = r_sat[QBITS-1] ? {1'b1, {QBITS{1'b0}}} : {1'b0, r_q[QBITS-1]};
endmodule

>>> sv/fcr_lane.sv
// One wavelength lane: conductor Fresnel reflectance, fully pipelined.
module fcr_lane
    import fcr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_ce,
    input  logic [C_W-1:0]   i_cos,
    input  logic [FIX_W-1:0] i_eta,
    input  logic [FIX_W-1:0] i_k,
    output logic [FIX_W-1:0] o_refl
);
    function automatic logic [53:0] sq27(input logic signed [26:0] x);
        logic signed [53:0] xe;
        xe = x;
        return 54'(xe * xe);
    endfunction

    // Stage 1: raw products.
    logic [31:0] r_ee, r_kk, r_ek;
    logic [30:0] r_cc;
    logic [C_W-1:0] r1_c;
    logic r1_z;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ee <= 32'(i_eta * i_eta);
            r_kk <= 32'(i_k * i_k);
            r_ek <= 32'(i_eta * i_k);
            r_cc <= 31'(i_cos * i_cos);
            r1_c <= i_cos;
            r1_z <= (i_eta == '0) && (i_k == '0);
        end
    end

    // Stage 2: z = n^2 - sin^2, and the real part of n^2.
    logic [30:0] n_cm;
    logic signed [32:0] n_a, n_diff;
    logic signed [32:0] r_a, r_diff;
    logic [30:0] r_b;
    logic [31:0] r2_ek;
    logic [C_W-1:0] r2_c;
    logic r2_z;
    assign n_cm   = ONE_Q30 - r_cc;
    assign n_a    = $signed({3'b000, r_ee[31:2]}) - $signed({3'b000, r_kk[31:2]})
                  - $signed({10'b0, n_cm[30:8]});
    assign n_diff = $signed({1'b0, r_ee}) - $signed({1'b0, r_kk});
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a    <= n_a;
            r_diff <= n_diff;
            r_b    <= r_ek[31:1];
            r2_ek  <= r_ek;
            r2_c   <= r1_c;
            r2_z   <= r1_z;
        end
    end

    // Stage 3: squares for |z| and the n^2 c products.
    logic signed [65:0] n_a2;
    logic [61:0] n_b2;
    logic signed [49:0] n_prf;
    logic [47:0] n_pif;
    logic [63:0] r_a2, r_b2;
    logic signed [49:0] r_prf;
    logic [47:0] r_pif;
    logic signed [32:0] r3_a;
    logic [C_W-1:0] r3_c;
    logic r3_z;
    assign n_a2  = r_a * r_a;
    assign n_b2  = r_b * r_b;
    assign n_prf = r_diff * $signed({1'b0, r2_c});
    assign n_pif = r2_ek * r2_c;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a2  <= n_a2[63:0];
            r_b2  <= {2'b00, n_b2};
            r_prf <= n_prf;
            r_pif <= n_pif;
            r3_a  <= r_a;
            r3_c  <= r2_c;
            r3_z  <= r2_z;
        end
    end

    // Stage 4: |z|^2, and scaling of n^2 c with truncation toward zero.
    logic [49:0] n_pabs;
    logic [25:0] n_psh;
    logic [63:0] r_s;
    logic signed [26:0] r_pr, r_pi;
    logic signed [32:0] r4_a;
    logic [C_W-1:0] r4_c;
    logic r4_z;
    assign n_pabs = r_prf[49] ? 50'(-r_prf) : 50'(r_prf);
    assign n_psh  = n_pabs[49:24];
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_s  <= r_a2 + r_b2;
            r_pr <= r_prf[49] ? -$signed({1'b0, n_psh}) : $signed({1'b0, n_psh});
            r_pi <= $signed({2'b00, r_pif[47:23]});
            r4_a <= r3_a;
            r4_c <= r3_c;
            r4_z <= r3_z;
        end
    end

    // |z| by square root, with the rest of the lane carried alongside.
    logic [31:0] w_m;
    logic [103:0] w_d1;
    logic signed [32:0] d1_a;
    logic signed [26:0] d1_pr, d1_pi;
    logic [C_W-1:0] d1_c;
    logic d1_z;
    fcr_isqrt #(.WIDTH(64)) u_sqrt_mag (
        .i_clk(i_clk), .i_ce(i_ce), .i_x(r_s), .o_root(w_m)
    );
    fcr_delay #(.WIDTH(104), .DEPTH(32)) u_dly_mag (
        .i_clk(i_clk), .i_ce(i_ce),
        .i_d({r4_a, r_pr, r_pi, r4_c, r4_z}), .o_q(w_d1)
    );
    assign {d1_a, d1_pr, d1_pi, d1_c, d1_z} = w_d1;

    // Stage 5: operands of the principal square root of z.
    logic signed [33:0] n_mpa, n_mma;
    logic [39:0] r_xr, r_xi;
    logic signed [26:0] r5_pr, r5_pi;
    logic [C_W-1:0] r5_c;
    logic r5_z;
    assign n_mpa = $signed({2'b00, w_m}) + d1_a;
    assign n_mma = $signed({2'b00, w_m}) - d1_a;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_xr  <= {n_mpa[32:0], 7'b0};
            r_xi  <= {n_mma[32:0], 7'b0};
            r5_pr <= d1_pr;
            r5_pi <= d1_pi;
            r5_c  <= d1_c;
            r5_z  <= d1_z;
        end
    end

    logic [19:0] w_wr, w_wi;
    logic [70:0] w_d2;
    logic signed [26:0] d2_pr, d2_pi;
    logic [C_W-1:0] d2_c;
    logic d2_z;
    fcr_isqrt #(.WIDTH(40)) u_sqrt_re (
        .i_clk(i_clk), .i_ce(i_ce), .i_x(r_xr), .o_root(w_wr)
    );
    fcr_isqrt #(.WIDTH(40)) u_sqrt_im (
        .i_clk(i_clk), .i_ce(i_ce), .i_x(r_xi), .o_root(w_wi)
    );
    fcr_delay #(.WIDTH(71), .DEPTH(20)) u_dly_w (
        .i_clk(i_clk), .i_ce(i_ce),
        .i_d({r5_pr, r5_pi, r5_c, r5_z}), .o_q(w_d2)
    );
    assign {d2_pr, d2_pi, d2_c, d2_z} = w_d2;

    // Stage 6: complex sums and differences.
    logic signed [26:0] n_wr, n_wi, n_c;
    logic signed [26:0] r_dr, r_di, r_nr, r_ni, r_cp, r_cm, r_wi;
    logic r6_z;
    assign n_wr = $signed({7'b0, w_wr});
    assign n_wi = $signed({7'b0, w_wi});
    assign n_c  = $signed({11'b0, d2_c});
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dr <= d2_pr + n_wr;
            r_di <= d2_pi + n_wi;
            r_nr <= d2_pr - n_wr;
            r_ni <= d2_pi - n_wi;
            r_cp <= n_c + n_wr;
            r_cm <= n_c - n_wr;
            r_wi <= n_wi;
            r6_z <= d2_z;
        end
    end

    // Stage 7: squares.
    logic [53:0] r_sdr, r_sdi, r_snr, r_sni, r_scp, r_scm, r_swi;
    logic r7_z;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_sdr <= sq27(r_dr);
            r_sdi <= sq27(r_di);
            r_snr <= sq27(r_nr);
            r_sni <= sq27(r_ni);
            r_scp <= sq27(r_cp);
            r_scm <= sq27(r_cm);
            r_swi <= sq27(r_wi);
            r7_z  <= r6_z;
        end
    end

    // Stage 8: squared magnitudes.
    logic [53:0] r_dpar, r_dperp, r_npar, r_nperp;
    logic r8_z;
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dpar  <= r_sdr + r_sdi;
            r_dperp <= r_scp + r_swi;
            r_npar  <= r_snr + r_sni;
            r_nperp <= r_scm + r_swi;
            r8_z    <= r7_z;
        end
    end

    // Ratios; an index of zero or a zero denominator forces full reflectance.
    logic [16:0] w_qpar, w_qperp;
    logic w_force, d3_z;
    assign w_force = r8_z || (r_dpar == '0) || (r_dperp == '0);
    fcr_div #(.WIDTH(54), .QBITS(16)) u_div_par (
        .i_clk(i_clk), .i_ce(i_ce), .i_num(r_npar), .i_den(r_dpar), .o_q(w_qpar)
    );
    fcr_div #(.WIDTH(54), .QBITS(16)) u_div_perp (
        .i_clk(i_clk), .i_ce(i_ce), .i_num(r_nperp), .i_den(r_dperp), .o_q(w_qperp)
    );
    fcr_delay #(.WIDTH(1), .DEPTH(16)) u_dly_z (
        .i_clk(i_clk), .i_ce(i_ce), .i_d(w_force), .o_q(d3_z)
    );

    // Final stage: average and saturate.
    logic [17:0] n_sum;
    logic [FIX_W-1:0] r_refl;
    assign n_sum = {1'b0, w_qpar} + {1'b0, w_qperp};
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            if (d3_z || n_sum[17]) begin
                r_refl <= REFL_MAX;
            end else begin
                r_refl <= n_sum[16:1];
            end
        end
    end

    assign o_refl = r_refl;
endmodule

>>> sv/conductor_fresnel_reflectance_top.sv
// Throughput: one word per cycle while the output is not stalled; every
// lane is a full pipeline whose depth includes the 32-stage magnitude square
// root and the 16-stage dividers.
// Reset: i_rst_n is synchronous, active low, and clears only the valid bits
// of the pipeline; the datapath registers carry no reset.
`include "assert_macros.svh"
module conductor_fresnel_reflectance_top
    import fcr_pkg::*;
#(
    parameter int LANES = LANES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // Fields from bit 0 up: cos_incident (17), eta_0..eta_{LANES-1} (16 each),
    // k_0..k_{LANES-1} (16 each), zero fill to a whole byte.
    input  logic [((COS_W+2*FIX_W*LANES+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // Fields from bit 0 up: refl_0..refl_{LANES-1} (16 each).
    output logic [FIX_W*LANES-1:0] o_m_tdata
);
    localparam int LAT = LANE_LAT + 1;

    // The whole pipeline moves as one; it advances whenever the output
    // register is empty or its word is being taken this cycle.
    logic w_ce;
    logic [LAT-1:0] r_valid;
    assign w_ce = !r_valid[LAT-1] || i_m_tready;

    // Clamp the incident cosine to [0, 1]: a negative code gives zero and
    // anything above 1.0 is held at 1.0.
    logic [COS_W-1:0] w_cos_raw;
    logic [C_W-1:0]   w_cos;
    assign w_cos_raw = i_s_tdata[COS_W-1:0];
    always_comb begin
        if (w_cos_raw[COS_W-1]) begin
            w_cos = '0;
        end else if (w_cos_raw[C_W-1:0] > ONE_Q15) begin
            w_cos = ONE_Q15;
        end else begin
            w_cos = w_cos_raw[C_W-1:0];
        end
    end

    // One lane per wavelength, all fed the same clamped cosine.
    logic [FIX_W*LANES-1:0] w_refl;
    for (genvar g = 0; g < LANES; g++) begin : g_lane
        fcr_lane u_lane (
            .i_clk  (i_clk),
            .i_ce   (w_ce),
            .i_cos  (w_cos),
            .i_eta  (i_s_tdata[COS_W + FIX_W*g +: FIX_W]),
            .i_k    (i_s_tdata[COS_W + FIX_W*(LANES+g) +: FIX_W]),
            .o_refl (w_refl[FIX_W*g +: FIX_W])
        );
    end

    // Valid bits track each word down the lane pipeline and into the
    // output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_ce) begin
            r_valid <= {r_valid[LAT-2:0], i_s_tvalid};
        end
    end

    // Merge stage: gather the lane results into one output word.
    logic [FIX_W*LANES-1:0] r_data;
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_data <= w_refl;
        end
    end

    assign o_s_tready = w_ce;
    assign o_m_tvalid = r_valid[LAT-1];
    assign o_m_tdata  = r_data;

    `FCR_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_tvalid && o_s_tready, r_valid[0])
    `FCR_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_ce, $stable(r_valid))
    `FCR_ASSERT_NEXT(a_drain_reaches, i_clk, i_rst_n, r_valid[LAT-2] && w_ce, o_m_tvalid)
endmodule

>>> tb/conductor_fresnel_reflectance_top_tb.sv
module conductor_fresnel_reflectance_top_tb;
    import fcr_pkg::*;

    localparam int NL     = LANES_DEF;
    localparam int IN_W   = ((COS_W + 2 * FIX_W * NL + 7) / 8) * 8;
    localparam int OUT_W  = FIX_W * NL;
    localparam int IDLE_LIMIT = 20000;

    typedef struct {
        logic signed [COS_W-1:0] cosv;
        logic [FIX_W-1:0] eta [NL];
        logic [FIX_W-1:0] kap [NL];
    } t_sample;

    logic i_clk;
    logic i_rst_n;
    logic i_s_tvalid;
    logic o_s_tready;
    // Fields from bit 0 up: cos_incident, eta_0..eta_3, k_0..k_3, zero fill.
    logic [IN_W-1:0] i_s_tdata;
    logic o_m_tvalid;
    logic i_m_tready;
    // Fields from bit 0 up: refl_0..refl_3.
    logic [OUT_W-1:0] o_m_tdata;

    conductor_fresnel_reflectance_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    logic [OUT_W-1:0] refl_queue [$];
    int mismatches = 0;
    int words_out = 0;
    int words_in = 0;
    int idle_cycles = 0;
    bit hold_sink = 0;
    bit sink_stalls = 1;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint unsigned mag_sq(longint re, longint im);
        return longint'(re * re) + longint'(im * im);
    endfunction

    // Long division to Q16; a quotient at or above one is pinned to 1.0.
    function automatic longint unsigned quot_q16(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned r;
        longint unsigned q;
        r = num;
        q = 0;
        if (num >= den) return 65536;
        for (int i = 0; i < 16; i++) begin
            r <<= 1;
            q <<= 1;
            if (r >= den) begin
                r -= den;
                q |= 1;
            end
        end
        return q;
    endfunction

    function automatic logic [FIX_W-1:0] lane_refl(longint unsigned c,
                                                   longint unsigned e,
                                                   longint unsigned k);
        longint a, b, wr, wi, pr, pi, dif, prod;
        longint unsigned m, dpar, dperp, npar, nperp, sum;
        if (e == 0 && k == 0) return REFL_MAX;
        a = longint'((e * e) >> 2) - longint'((k * k) >> 2)
            - longint'((64'd1073741824 - c * c) >> 8);
        b = longint'((e * k) >> 1);
        m = root64(mag_sq(a, b));
        wr = longint'(root64(longint'(longint'(m) + a) << 7));
        wi = longint'(root64(longint'(longint'(m) - a) << 7));
        dif = longint'(e * e) - longint'(k * k);
        prod = dif * longint'(c);
        // Truncate toward zero.
        pr = (prod < 0) ? -((-prod) >>> 24) : (prod >>> 24);
        pi = longint'((e * k * c) >> 23);
        dpar = mag_sq(pr + wr, pi + wi);
        dperp = mag_sq(longint'(c) + wr, wi);
        if (dpar == 0 || dperp == 0) return REFL_MAX;
        npar = mag_sq(pr - wr, pi - wi);
        nperp = mag_sq(longint'(c) - wr, -wi);
        sum = (quot_q16(npar, dpar) + quot_q16(nperp, dperp)) >> 1;
        return (sum > 65535) ? REFL_MAX : sum[FIX_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] predict_refl(t_sample s);
        logic [OUT_W-1:0] r;
        longint unsigned c;
        if (s.cosv < 0) c = 0;
        else if (s.cosv > $signed({1'b0, ONE_Q15})) c = 64'(ONE_Q15);
        else c = 64'(s.cosv);
        for (int i = 0; i < NL; i++)
            r[i*FIX_W +: FIX_W] = lane_refl(c, 64'(s.eta[i]), 64'(s.kap[i]));
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_sample(t_sample s);
        logic [IN_W-1:0] d;
        d = '0;
        d[COS_W-1:0] = s.cosv;
        for (int i = 0; i < NL; i++) begin
            d[COS_W + i*FIX_W +: FIX_W] = s.eta[i];
            d[COS_W + (NL+i)*FIX_W +: FIX_W] = s.kap[i];
        end
        return d;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Sends one word and records its prediction when it is accepted. Valid
    // stays high after acceptance; it drops only for a gap or a drain.
    task automatic send_word(t_sample s, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= pack_sample(s);
        do @(posedge i_clk); while (!o_s_tready);
        refl_queue.push_back(predict_refl(s));
        words_in++;
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        int p;
        p = $urandom_range(9);
        if (p < 6) s.cosv = 17'($urandom_range(32768, 0));
        else s.cosv = 17'($urandom);
        for (int i = 0; i < NL; i++) begin
            // Mostly physical metals near a few units, sometimes full range.
            if ($urandom_range(3) != 0) begin
                s.eta[i] = 16'($urandom_range(16383, 1));
                s.kap[i] = 16'($urandom_range(20479, 0));
            end else begin
                s.eta[i] = 16'($urandom);
                s.kap[i] = 16'($urandom);
            end
        end
        return s;
    endfunction

    // Output side: random stalls, a long forced hold when requested, or always ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_sink) begin
            i_m_tready <= 1'b0;
        end else if (sink_stalls) begin
            i_m_tready <= ($urandom_range(99) < 70);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Scoreboard: every accepted output word is checked against the oldest
    // prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            words_out++;
            if (refl_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected output word %h", o_m_tdata);
            end else begin
                logic [OUT_W-1:0] want;
                want = refl_queue.pop_front();
                for (int i = 0; i < NL; i++) begin
                    if (o_m_tdata[i*FIX_W +: FIX_W] !== want[i*FIX_W +: FIX_W]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("refl_%0d mismatch: expected %0d actual %0d",
                                     i, want[i*FIX_W +: FIX_W],
                                     o_m_tdata[i*FIX_W +: FIX_W]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout waiting for a handshake");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (refl_queue.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        t_sample s;
        logic signed [COS_W-1:0] cosl [8];
        cosl = '{17'sh10000, -17'sd1, 17'sd0, 17'sd1, 17'sd16384,
                 17'sd32767, 17'sd32768, 17'sh0FFFF};
        foreach (cosl[j]) begin
            s.cosv = cosl[j];
            // Lanes: ordinary metal, index zero, extreme eta, extreme k.
            s.eta[0] = 16'h0800; s.kap[0] = 16'h3000;
            s.eta[1] = 16'h0000; s.kap[1] = 16'h0000;
            s.eta[2] = (j % 2) ? 16'hFFFF : 16'h0001; s.kap[2] = 16'h0000;
            s.eta[3] = 16'h0001; s.kap[3] = (j % 2) ? 16'hFFFF : 16'h0001;
            send_word(s, 0);
        end
        // Grazing and normal incidence; dielectric-like lanes drive c + w near zero.
        for (int j = 0; j < 6; j++) begin
            s.cosv = (j < 3) ? 17'sd0 : 17'sd32768;
            for (int i = 0; i < NL; i++) begin
                s.eta[i] = (j % 3 == 0) ? 16'h1000 : (j % 3 == 1) ? 16'hFFFF : 16'h0001;
                s.kap[i] = (i % 2) ? 16'hFFFF : 16'h0000;
            end
            send_word(s, 0);
        end
        drain();
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_word(rand_sample(), 1);
    endtask

    // The sink holds off while the source keeps offering, so the pipeline
    // fills and input ready must drop.
    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1;
                repeat (300) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int n = 0; n < 150; n++) send_word(rand_sample(), 0);
        join
        drain();
    endtask

    task automatic test_full_rate();
        sink_stalls = 0;
        for (int n = 0; n < 120; n++) send_word(rand_sample(), 0);
        drain();
        sink_stalls = 1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200);
        drain();
        test_backpressure();
        test_full_rate();
        test_random(170);
        drain();
        repeat (LANE_LAT + 20) @(posedge i_clk);
        $display("Sent %0d words and checked %0d results over four lanes,", words_in,
                 words_out);
        $display("with directed edges, random stalls, a long sink hold and full rate.");
        if (mismatches == 0 && refl_queue.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, refl_queue.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
